// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General property, checked at every rising edge outside reset.
`define PBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication from a condition to a consequence in the same cycle.
`define PBM_ASSERT_IMP(lbl, cond, cons, msg) \
  `PBM_ASSERT(lbl, (cond) |-> (cons), msg)

`endif

// ===== rtl/core/pbm_pkg.sv =====
// ----------------------------------------------------------------------------
// Poll busyness monitor package
// Types, constants and encodings shared by the monitor's modules.
// ----------------------------------------------------------------------------
package pbm_pkg;

  localparam int unsigned CoresDefault = 128;
  localparam int unsigned QDepth       = 2;

  localparam logic [63:0] IntervalReset = 64'd1000000;
  localparam logic [63:0] StaleReset    = 64'd1000000000;

  localparam logic [13:0] FullRaw   = 14'd10000;
  localparam logic [5:0]  RunLimit  = 6'd32;
  localparam logic [7:0]  BusyUnset = 8'hFF;

  // Register indexes of the configuration port.
  localparam logic CfgInterval = 1'b0;
  localparam logic CfgStale    = 1'b1;

  // Item functions carried on tuser.
  localparam logic FnPoll  = 1'b0;
  localparam logic FnQuery = 1'b1;

  // Item as classified by the front end.
  typedef struct packed {
    logic        poll;
    logic        in_range;
    logic        empty;
    logic [6:0]  core;
    logic [63:0] now;
  } pbm_item_t;

  // Per-core statistics entry.
  typedef struct packed {
    logic [63:0] start;
    logic [63:0] empty_ticks;
    logic [63:0] last_poll;
    logic        was_empty;
    logic [5:0]  run;
    logic [13:0] smoothed;
    logic [7:0]  busy;
  } pbm_entry_t;

  localparam pbm_entry_t EntryReset = '{
    start: 64'd0, empty_ticks: 64'd0, last_poll: 64'd0, was_empty: 1'b1,
    run: 6'd0, smoothed: 14'd0, busy: BusyUnset
  };

  // Queue handshake between front and back.
  typedef struct packed {
    logic      valid;
    pbm_item_t item;
  } pbm_q_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_DECIDE,
    S_MUL_LO,
    S_MUL_HI,
    S_DIV,
    S_SMOOTH,
    S_PCT,
    S_FIN
  } pbm_state_e;

endpackage

// ===== rtl/core/poll_busyness_monitor_top.sv =====
// Queries, skipped polls and interval-opening polls go straight to the result
// register; other polls are checked against the interval. One item is handled at
// a time, with up to two more queued. A poll that closes an interval runs the
// 78-step divider unless it was all idle; a stalled result holds the sequencer.
// Reset clears the configuration to its defaults and marks every table entry
// unwritten, so all cores read as inactive at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Poll busyness monitor top level
// Configuration registers, front end queue and back end sequencer.
// ----------------------------------------------------------------------------
module poll_busyness_monitor_top import pbm_pkg::*; #(
  parameter int unsigned CORES = CoresDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [63:0] cfg_data_i,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // func[0]
  input  logic        s_axis_tuser_i,
  // core[6:0], now[70:7], rx_count[86:71], zero fill[87]
  input  logic [87:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // busyness[7:0], raw_busyness[21:8], zero fill[23:22]
  output logic [23:0] m_axis_tdata_o
);

  logic [63:0] interval_q, stale_q;
  pbm_q_t      q;
  logic        q_pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= IntervalReset;
      stale_q    <= StaleReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgInterval: interval_q <= cfg_data_i;
        CfgStale:    stale_q    <= cfg_data_i;
        default:     ;
      endcase
    end
  end

  pbm_front #(.CORES(CORES)) u_front (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid_i,
    .s_axis_tready_o,
    .s_axis_tuser_i,
    .s_axis_tdata_i,
    .q_o     (q),
    .q_pop_i (q_pop)
  );

  pbm_back #(.CORES(CORES)) u_back (
    .clk_i,
    .rst_ni,
    .interval_ticks_i (interval_q),
    .stale_ticks_i    (stale_q),
    .q_i              (q),
    .q_pop_o          (q_pop),
    .m_axis_tvalid_o,
    .m_axis_tready_i,
    .m_axis_tdata_o
  );

endmodule

// ===== rtl/core/pbm_front.sv =====
// ----------------------------------------------------------------------------
// Poll busyness monitor front end
// Accepts stream transfers, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module pbm_front import pbm_pkg::*; #(
  parameter int unsigned CORES = CoresDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // func[0]
  input  logic        s_axis_tuser_i,
  // core[6:0], now[70:7], rx_count[86:71], zero fill[87]
  input  logic [87:0] s_axis_tdata_i,
  output pbm_q_t      q_o,
  input  logic        q_pop_i
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;

  pbm_item_t            q_mem [QDepth];
  logic [PtrW-1:0]      wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]        cnt_q, cnt_d;
  logic                 push;
  pbm_item_t            item;

  always_comb begin
    item.poll     = (s_axis_tuser_i == FnPoll);
    item.core     = s_axis_tdata_i[6:0];
    item.now      = s_axis_tdata_i[70:7];
    item.empty    = (s_axis_tdata_i[86:71] == 16'd0);
    item.in_range = (32'(s_axis_tdata_i[6:0]) < CORES);
  end

  assign s_axis_tready_o = (cnt_q != (PtrW+1)'(QDepth));
  assign push            = s_axis_tvalid_i & s_axis_tready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    cnt_d = cnt_q + (PtrW+1)'(push) - (PtrW+1)'(q_pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= item;
    end
  end

  assign q_o.valid = (cnt_q != '0);
  assign q_o.item  = q_mem[rd_ptr_q];

endmodule

// ===== rtl/core/pbm_back.sv =====
// ----------------------------------------------------------------------------
// Poll busyness monitor back end
// Sequencer over the per-core table with an iterative idle-share divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbm_back import pbm_pkg::*; #(
  parameter int unsigned CORES = CoresDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] interval_ticks_i,
  input  logic [63:0] stale_ticks_i,
  input  pbm_q_t      q_i,
  output logic        q_pop_o,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // busyness[7:0], raw_busyness[21:8], zero fill[23:22]
  output logic [23:0] m_axis_tdata_o
);

  localparam int unsigned IdxW = (CORES > 1) ? $clog2(CORES) : 1;

  pbm_state_e  state_q, state_d;
  pbm_item_t   item_q;
  pbm_entry_t  mem [CORES];
  logic [CORES-1:0] valid_q;
  pbm_entry_t  rdata_q, ent_c, ent_q;
  pbm_entry_t  ent_calc, ent_pct;
  logic        rvalid_q;
  logic [IdxW-1:0] addr;

  logic [63:0] acc_q, elapsed_q, rem_q;
  logic [77:0] prod_q;
  logic [6:0]  cnt_q;
  logic [13:0] quot_q, cur_q, raw_q;

  logic        skip_c, open_c, work_c;
  logic        out_free, mem_we;
  logic [64:0] div_sh;
  logic        div_ge;
  logic [13:0] smooth_prev;
  logic [15:0] smooth_sum;
  logic [31:0] smooth_prod;
  logic [13:0] smooth_idle;
  logic [26:0] pct_prod;
  logic [7:0]  res_busy;
  logic [13:0] res_raw;
  logic [63:0] since_start;

  logic        m_valid_q;
  logic [23:0] m_data_q;

  assign addr = IdxW'(item_q.core);

  // Entry as seen after reset: an entry never written holds reset values.
  assign ent_c  = rvalid_q ? rdata_q : EntryReset;
  assign skip_c = (ent_c.was_empty == item_q.empty) && (ent_c.run < RunLimit);
  assign open_c = (ent_c.start == 64'd0);
  assign work_c = item_q.poll & item_q.in_range;

  assign out_free = ~m_valid_q | m_axis_tready_i;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (q_i.valid) state_d = S_READ;
      S_READ:   state_d = S_CALC;
      S_CALC: begin
        if (work_c && !skip_c && !open_c) state_d = S_DECIDE;
        else                              state_d = S_FIN;
      end
      S_DECIDE: begin
        if (elapsed_q <= interval_ticks_i) state_d = S_FIN;
        else if (acc_q >= elapsed_q)       state_d = S_SMOOTH;
        else                               state_d = S_MUL_LO;
      end
      S_MUL_LO: state_d = S_MUL_HI;
      S_MUL_HI: state_d = S_DIV;
      S_DIV:    if (cnt_q == 7'd0) state_d = S_SMOOTH;
      S_SMOOTH: state_d = S_PCT;
      S_PCT:    state_d = S_FIN;
      S_FIN:    if (out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    q_pop_o = 1'b0;
    mem_we  = 1'b0;
    case (state_q)
      S_IDLE:  q_pop_o = q_i.valid;
      S_FIN:   mem_we  = out_free & work_c;
      default: begin
        q_pop_o = 1'b0;
        mem_we  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Table storage; the valid bits stand in for the reset values.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= ent_q;
    end
    rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      rvalid_q <= valid_q[addr];
      if (mem_we) valid_q[addr] <= 1'b1;
    end
  end

  // Entry after the run check and, for the first handled poll, the interval opening.
  always_comb begin
    ent_calc = ent_c;
    if (work_c) begin
      if (skip_c) begin
        ent_calc.run = ent_c.run + 6'd1;
      end else begin
        ent_calc.run       = 6'd0;
        ent_calc.last_poll = item_q.now;
        ent_calc.was_empty = item_q.empty;
        if (open_c) begin
          ent_calc.busy        = 8'd0;
          ent_calc.smoothed    = 14'd0;
          ent_calc.start       = item_q.now;
          ent_calc.empty_ticks = 64'd0;
        end
      end
    end
  end

  // Entry after an interval has closed.
  always_comb begin
    ent_pct             = ent_q;
    ent_pct.smoothed    = raw_q;
    ent_pct.busy        = 8'(pct_prod >> 19);
    ent_pct.start       = item_q.now;
    ent_pct.empty_ticks = 64'd0;
  end

  // Divider step: one quotient bit per cycle.
  assign div_sh = {rem_q, prod_q[77]};
  assign div_ge = (div_sh >= {1'b0, elapsed_q});

  // Smoothing 1:4 with the previous idle share; divide by 5 by reciprocal.
  assign smooth_prev = FullRaw - ent_q.smoothed;
  assign smooth_sum  = 16'(cur_q) + {smooth_prev, 2'b00};
  assign smooth_prod = smooth_sum * 16'd52429;
  assign smooth_idle = 14'(smooth_prod >> 18);
  assign pct_prod    = (27'(raw_q) + 27'd50) * 27'd5243;

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (q_i.valid) item_q <= q_i.item;
      S_CALC: begin
        ent_q <= ent_calc;
        acc_q <= ent_c.empty_ticks +
                 (ent_c.was_empty ? (item_q.now - ent_c.last_poll) : 64'd0);
        elapsed_q <= item_q.now - ent_c.start;
      end
      S_DECIDE: begin
        if (elapsed_q <= interval_ticks_i) ent_q.empty_ticks <= acc_q;
        cur_q <= FullRaw;
      end
      S_MUL_LO: prod_q <= 78'(46'(acc_q[31:0]) * 46'd10000);
      S_MUL_HI: begin
        prod_q <= prod_q + (78'(46'(acc_q[63:32]) * 46'd10000) << 32);
        rem_q  <= 64'd0;
        cnt_q  <= 7'd77;
        quot_q <= 14'd0;
      end
      S_DIV: begin
        rem_q  <= div_ge ? 64'(div_sh - {1'b0, elapsed_q}) : div_sh[63:0];
        quot_q <= {quot_q[12:0], div_ge};
        prod_q <= {prod_q[76:0], 1'b0};
        cnt_q  <= cnt_q - 7'd1;
        if (cnt_q == 7'd0) cur_q <= {quot_q[12:0], div_ge};
      end
      S_SMOOTH: raw_q <= FullRaw - smooth_idle;
      S_PCT:    ent_q <= ent_pct;
      default: ;
    endcase
  end

  // Result: busyness reads as unset when the core is out of range, inactive or stale.
  assign since_start = item_q.now - ent_q.start;
  always_comb begin
    res_busy = ent_q.busy;
    res_raw  = ent_q.smoothed;
    if (!item_q.in_range || ent_q.start == 64'd0 || since_start > stale_ticks_i) begin
      res_busy = BusyUnset;
    end
    if (!item_q.in_range) res_raw = 14'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == S_FIN && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_FIN && out_free) begin
      m_data_q <= {2'b00, res_raw, res_busy};
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

  `PBM_ASSERT_IMP(a_pop_idle, q_pop_o, state_q == S_IDLE, "queue popped while busy")
  `PBM_ASSERT_IMP(a_busy_range, mem_we,
    ($signed(ent_q.busy) >= -8'sd1) && ($signed(ent_q.busy) <= 8'sd100),
    "stored busyness out of range")
  `PBM_ASSERT_IMP(a_raw_range, mem_we, ent_q.smoothed <= FullRaw, "stored raw out of range")
  `PBM_ASSERT_IMP(a_share_range, state_q == S_SMOOTH, cur_q <= FullRaw,
    "idle share above full scale")

endmodule
